[rtl/sfr_pkg.sv]
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the stuffed frame receiver and its checker.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int unsigned MAX_PAYLOAD_DEF = 4096;
	localparam logic [7:0]  MARKER_RESET    = 8'd126;
	localparam int unsigned BYTE_W          = 8;
	localparam int unsigned IDX_W           = 12;
	localparam int unsigned LEN_W           = 16;
	localparam int unsigned SUM_W           = 16;
	localparam int unsigned CTR_W           = 32;

	typedef enum logic [2:0] {
		PH_WAIT     = 3'd0,
		PH_LEN_HIGH = 3'd1,
		PH_DATA     = 3'd2,
		PH_SUM_LOW  = 3'd3,
		PH_SUM_HIGH = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_GOOD     = 3'd1,
		EV_SUM_ERR  = 3'd2,
		EV_TOO_LONG = 3'd3,
		EV_RESTART  = 3'd4
	} event_t;

endpackage

[rtl/stuffed_frame_receiver.sv]
// ----------------------------------------------------------------------------
// stuffed_frame_receiver
// Byte-stuffed frame deframer with a 16-bit byte-sum checksum.
// ----------------------------------------------------------------------------
// Takes one raw link byte per input transaction and returns exactly one result
// transaction per byte. A doubled marker byte is one literal byte; a marker
// followed by any other byte opens a frame, that byte being the low length
// byte. Then come the high length byte, the payload (passed out byte by byte
// with its index) and a little-endian 16-bit checksum of the payload byte sum.
// Each result carries the frame event (good, checksum error, too long,
// restart inside an open frame), the declared length and four wrapping error
// and good-frame counters. Throughput is one byte per clock while out_ready
// stays high: a byte is held in an input register, and the frame state and
// counters update as it moves into the output register, where its result is
// visible and can be taken. Both registers stall only on out_ready low. The
// marker register is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while the block is idle, as the block itself does not enforce
// this. Its reset value is 126.
module stuffed_frame_receiver
	import sfr_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_wr_en,
	input  logic [BYTE_W-1:0]   cfg_wr_data,
	// input channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [BYTE_W-1:0]   rx_byte,
	// result channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic                payload_valid,
	output logic [BYTE_W-1:0]   payload_byte,
	output logic [IDX_W-1:0]    payload_index,
	output logic [2:0]          frame_event,
	output logic [LEN_W-1:0]    frame_length,
	output logic [CTR_W-1:0]    good_frames,
	output logic [CTR_W-1:0]    checksum_errors,
	output logic [CTR_W-1:0]    length_errors,
	output logic [CTR_W-1:0]    restart_errors
);

	// Payload counter must reach MAX_PAYLOAD itself.
	localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);

	// Marker register.
	logic [BYTE_W-1:0] marker_q;

	// Input stage.
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              advance;

	// Frame state.
	logic              esc_q,   esc_nxt;
	phase_t            phase_q, phase_nxt;
	logic [LEN_W-1:0]  len_q,   len_nxt;
	logic [CNT_W-1:0]  cnt_q,   cnt_nxt;
	logic [SUM_W-1:0]  sum_q,   sum_nxt;
	logic [BYTE_W-1:0] cks_lo_q, cks_lo_nxt;
	logic [CTR_W-1:0]  good_q,  good_nxt;
	logic [CTR_W-1:0]  serr_q,  serr_nxt;
	logic [CTR_W-1:0]  lerr_q,  lerr_nxt;
	logic [CTR_W-1:0]  rerr_q,  rerr_nxt;

	// Result of the current byte.
	logic              pv;
	logic [BYTE_W-1:0] pbyte;
	logic [IDX_W-1:0]  pindex;
	event_t            ev;
	logic [CNT_W-1:0]  cnt_inc;

	// Output register.
	logic              out_valid_q;
	logic              pv_q;
	logic [BYTE_W-1:0] pbyte_q;
	logic [IDX_W-1:0]  pindex_q;
	event_t            ev_q;

	// Move the held byte on when the output register is empty or being drained.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= MARKER_RESET;
		end else if (cfg_wr_en) begin
			marker_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	assign cnt_inc = cnt_q + 1'b1;

	// Next frame state and the result for the byte in the input stage.
	always_comb begin
		esc_nxt    = esc_q;
		phase_nxt  = phase_q;
		len_nxt    = len_q;
		cnt_nxt    = cnt_q;
		sum_nxt    = sum_q;
		cks_lo_nxt = cks_lo_q;
		good_nxt   = good_q;
		serr_nxt   = serr_q;
		lerr_nxt   = lerr_q;
		rerr_nxt   = rerr_q;
		pv         = 1'b0;
		pbyte      = '0;
		pindex     = '0;
		ev         = EV_NONE;

		if (esc_q && byte_s1 != marker_q) begin
			// Marker then a non-marker: open a new frame.
			esc_nxt = 1'b0;
			if (phase_q != PH_WAIT) begin
				rerr_nxt = rerr_q + 1'b1;
				ev       = EV_RESTART;
			end
			phase_nxt  = PH_LEN_HIGH;
			len_nxt    = LEN_W'(byte_s1);
			cnt_nxt    = '0;
			sum_nxt    = '0;
			cks_lo_nxt = '0;
		end else if (!esc_q && byte_s1 == marker_q) begin
			// First marker: hold it until the next byte decides.
			esc_nxt = 1'b1;
		end else begin
			// Plain byte or an unstuffed literal marker.
			esc_nxt = 1'b0;
			case (phase_q)
				PH_WAIT: begin
					phase_nxt = PH_WAIT;
				end
				PH_LEN_HIGH: begin
					len_nxt   = {byte_s1, len_q[7:0]};
					phase_nxt = ({byte_s1, len_q[7:0]} == '0) ? PH_SUM_LOW : PH_DATA;
				end
				PH_DATA: begin
					pv      = 1'b1;
					pbyte   = byte_s1;
					pindex  = IDX_W'(cnt_q);
					cnt_nxt = cnt_inc;
					sum_nxt = sum_q + SUM_W'(byte_s1);
					if (32'(cnt_inc) >= 32'(len_q)) begin
						phase_nxt = PH_SUM_LOW;
					end else if (cnt_inc == CNT_W'(MAX_PAYLOAD)) begin
						lerr_nxt  = lerr_q + 1'b1;
						phase_nxt = PH_WAIT;
						ev        = EV_TOO_LONG;
					end
				end
				PH_SUM_LOW: begin
					cks_lo_nxt = byte_s1;
					phase_nxt  = PH_SUM_HIGH;
				end
				PH_SUM_HIGH: begin
					if ({byte_s1, cks_lo_q} == sum_q) begin
						good_nxt = good_q + 1'b1;
						ev       = EV_GOOD;
					end else begin
						serr_nxt = serr_q + 1'b1;
						ev       = EV_SUM_ERR;
					end
					phase_nxt = PH_WAIT;
				end
				default: begin
					phase_nxt = PH_WAIT;
				end
			endcase
		end
	end

	// Frame state register: update only when the byte moves to the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q    <= 1'b0;
			phase_q  <= PH_WAIT;
			len_q    <= '0;
			cnt_q    <= '0;
			sum_q    <= '0;
			cks_lo_q <= '0;
			good_q   <= '0;
			serr_q   <= '0;
			lerr_q   <= '0;
			rerr_q   <= '0;
		end else if (advance) begin
			esc_q    <= esc_nxt;
			phase_q  <= phase_nxt;
			len_q    <= len_nxt;
			cnt_q    <= cnt_nxt;
			sum_q    <= sum_nxt;
			cks_lo_q <= cks_lo_nxt;
			good_q   <= good_nxt;
			serr_q   <= serr_nxt;
			lerr_q   <= lerr_nxt;
			rerr_q   <= rerr_nxt;
		end
	end

	// Output register: load on advance, drop valid once the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pv_q     <= pv;
			pbyte_q  <= pbyte;
			pindex_q <= pindex;
			ev_q     <= ev;
		end
	end

	// Length and counters are the frame state after this byte.
	assign out_valid       = out_valid_q;
	assign payload_valid   = pv_q;
	assign payload_byte    = pbyte_q;
	assign payload_index   = pindex_q;
	assign frame_event     = ev_q;
	assign frame_length    = len_q;
	assign good_frames     = good_q;
	assign checksum_errors = serr_q;
	assign length_errors   = lerr_q;
	assign restart_errors  = rerr_q;

endmodule

[rtl/sfr_checker.sv]
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level assertions for the stuffed frame receiver, bound into the receiver.
// ----------------------------------------------------------------------------
module sfr_checker
	import sfr_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic              payload_valid,
	input logic [BYTE_W-1:0] payload_byte,
	input logic [IDX_W-1:0]  payload_index,
	input logic [2:0]        frame_event,
	input logic [LEN_W-1:0]  frame_length
);

	// A stalled result transaction holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(payload_byte)
			&& $stable(payload_index) && $stable(frame_event))
		else $error("result changed while stalled");

	// A payload byte only ends a frame by running too long.
	a_payload_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && payload_valid |-> frame_event == EV_NONE
			|| frame_event == EV_TOO_LONG)
		else $error("payload byte with a frame-end event");

	// Empty payload slots are zero.
	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !payload_valid |-> payload_byte == '0 && payload_index == '0)
		else $error("payload fields set without a payload byte");

	// Index stays inside the declared length.
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && payload_valid |-> LEN_W'(payload_index) < frame_length)
		else $error("payload index beyond declared length");

endmodule

bind stuffed_frame_receiver sfr_checker u_sfr_checker (.*);

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte-stuffed frame receiver.
// ----------------------------------------------------------------------------
// Drives raw link bytes through the valid/ready input channel. Each accepted
// byte runs through a bit-accurate deframer model kept here. The model pushes
// the expected result transaction onto a queue. A checker pops one entry for
// each accepted result transaction and compares every field. The stimulus has
// four parts:
//   - a short directed sequence at the reset marker value
//   - frames under marker values 0, 255 and a random value, including an
//     escape left pending while the marker is rewritten
//   - two maximum-size frames: one that exactly fills the payload limit and
//     one that overruns it
//   - about 400 random bytes, mostly well-formed frames, with noise and cut
//     frames mixed in
// Both sides insert random idle cycles, with stretches of full rate between
// them.
// ----------------------------------------------------------------------------
module tb_top;
	import sfr_pkg::*;

	// Worst case is roughly 9k link bytes; this limit leaves room for the pacing.
	localparam int CYCLE_LIMIT = 400_000;
	localparam int RANDOM_BYTES = 400;

	// one expected result transaction
	typedef struct {
		logic              pay_valid;
		logic [BYTE_W-1:0] pay_byte;
		logic [IDX_W-1:0]  pay_index;
		event_t            evt;
		logic [LEN_W-1:0]  length;
		logic [CTR_W-1:0]  good_cnt;
		logic [CTR_W-1:0]  sum_err_cnt;
		logic [CTR_W-1:0]  too_long_cnt;
		logic [CTR_W-1:0]  restart_cnt;
	} deframe_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [BYTE_W-1:0] cfg_wr_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [BYTE_W-1:0] rx_byte = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              payload_valid;
	logic [BYTE_W-1:0] payload_byte;
	logic [IDX_W-1:0]  payload_index;
	logic [2:0]        frame_event;
	logic [LEN_W-1:0]  frame_length;
	logic [CTR_W-1:0]  good_frames;
	logic [CTR_W-1:0]  checksum_errors;
	logic [CTR_W-1:0]  length_errors;
	logic [CTR_W-1:0]  restart_errors;

	// deframer model state; cur_marker mirrors the marker register
	logic [BYTE_W-1:0] cur_marker = MARKER_RESET;
	logic              esc_pending = 1'b0;
	phase_t            phase = PH_WAIT;
	logic [LEN_W-1:0]  decl_len = '0;
	logic [12:0]       rcvd_count = '0;
	logic [SUM_W-1:0]  run_sum = '0;
	logic [BYTE_W-1:0] sum_low = '0;
	logic [CTR_W-1:0]  n_good = '0;
	logic [CTR_W-1:0]  n_sum_err = '0;
	logic [CTR_W-1:0]  n_too_long = '0;
	logic [CTR_W-1:0]  n_restart = '0;

	deframe_result_t expected_results[$];
	deframe_result_t head;

	int  errors = 0;
	int  bytes_sent = 0;
	int  results_checked = 0;
	int  marker_writes = 0;
	int  cycles = 0;
	bit  pacing = 1'b1;

	stuffed_frame_receiver DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.payload_valid  (payload_valid),
		.payload_byte   (payload_byte),
		.payload_index  (payload_index),
		.frame_event    (frame_event),
		.frame_length   (frame_length),
		.good_frames    (good_frames),
		.checksum_errors(checksum_errors),
		.length_errors  (length_errors),
		.restart_errors (restart_errors)
	);

	always #5 clk = ~clk;

	// Run watchdog: stop the run if it hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("FAIL stuffed_frame_receiver");
			$finish;
		end
	end

	// Advance the deframer model by one accepted link byte and queue the
	// result that the byte must produce.
	function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
		deframe_result_t r;
		bit              to_phase;
		r.pay_valid = 1'b0;
		r.pay_byte  = '0;
		r.pay_index = '0;
		r.evt       = EV_NONE;
		to_phase    = 1'b1;
		if (esc_pending) begin
			esc_pending = 1'b0;
			// marker + non-marker opens a frame; that byte is the low length byte
			if (b != cur_marker) begin
				if (phase != PH_WAIT) begin
					n_restart = n_restart + 1;
					r.evt = EV_RESTART;
				end
				phase = PH_LEN_HIGH;
				decl_len = {8'h00, b};
				rcvd_count = '0;
				run_sum = '0;
				sum_low = '0;
				to_phase = 1'b0;
			end
		end else if (b == cur_marker) begin
			esc_pending = 1'b1;
			to_phase = 1'b0;
		end
		if (to_phase) begin
			case (phase)
				PH_LEN_HIGH: begin
					decl_len[15:8] = b;
					phase = (decl_len == 0) ? PH_SUM_LOW : PH_DATA;
				end
				PH_DATA: begin
					r.pay_valid = 1'b1;
					r.pay_byte = b;
					r.pay_index = rcvd_count[IDX_W-1:0];
					rcvd_count = rcvd_count + 13'd1;
					run_sum = run_sum + SUM_W'(b);
					// a full declared length wins over the payload limit
					if (LEN_W'(rcvd_count) >= decl_len) begin
						phase = PH_SUM_LOW;
					end else if (rcvd_count >= MAX_PAYLOAD_DEF) begin
						n_too_long = n_too_long + 1;
						phase = PH_WAIT;
						r.evt = EV_TOO_LONG;
					end
				end
				PH_SUM_LOW: begin
					sum_low = b;
					phase = PH_SUM_HIGH;
				end
				PH_SUM_HIGH: begin
					if ({b, sum_low} == run_sum) begin
						n_good = n_good + 1;
						r.evt = EV_GOOD;
					end else begin
						n_sum_err = n_sum_err + 1;
						r.evt = EV_SUM_ERR;
					end
					phase = PH_WAIT;
				end
				default: phase = PH_WAIT;
			endcase
		end
		r.length       = decl_len;
		r.good_cnt     = n_good;
		r.sum_err_cnt  = n_sum_err;
		r.too_long_cnt = n_too_long;
		r.restart_cnt  = n_restart;
		expected_results.push_back(r);
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name,
				want, got);
		end
	endtask

	// Result checker: sample on the rising edge and pop the oldest expectation
	// for each accepted transaction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: result transaction with nothing expected, event %0d",
					$time, frame_event);
			end else begin
				head = expected_results.pop_front();
				results_checked++;
				compare_field("payload_valid", 32'(head.pay_valid), 32'(payload_valid));
				compare_field("payload_byte", 32'(head.pay_byte), 32'(payload_byte));
				compare_field("payload_index", 32'(head.pay_index), 32'(payload_index));
				compare_field("frame_event", 32'(head.evt), 32'(frame_event));
				compare_field("frame_length", 32'(head.length), 32'(frame_length));
				compare_field("good_frames", head.good_cnt, good_frames);
				compare_field("checksum_errors", head.sum_err_cnt, checksum_errors);
				compare_field("length_errors", head.too_long_cnt, length_errors);
				compare_field("restart_errors", head.restart_cnt, restart_errors);
			end
		end
	end

	// Result sink: before each transaction, hold ready low for a random stall while pacing is on.
	// Drive on the falling edge.
	initial begin : result_sink
		int stall;
		forever begin
			@(negedge clk);
			stall = pacing ? $urandom_range(0, 4) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(arst_n && out_valid));
		end
	end

	// Send one raw link byte. Enter and leave on a falling edge. When there
	// is no gap, valid stays high into the next transaction.
	task automatic send_link_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = pacing ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		deframe_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Send a frame content byte; double it when it equals the marker.
	task automatic send_escaped_byte(input logic [BYTE_W-1:0] b);
		send_link_byte(b);
		if (b == cur_marker)
			send_link_byte(b);
	endtask

	// Send a frame: marker, length, payload and checksum. If cut_at is not
	// negative and is below the length, stop after cut_at payload bytes.
	// A low length byte equal to the marker cannot open a frame, so flip
	// its bit 0.
	task automatic send_frame(input logic [LEN_W-1:0] len, input bit bad_sum,
			input int cut_at);
		logic [SUM_W-1:0]  sum;
		logic [BYTE_W-1:0] b;
		int                n;
		if (len[7:0] == cur_marker)
			len[0] = ~len[0];
		n = (cut_at >= 0 && cut_at < int'(len)) ? cut_at : int'(len);
		sum = '0;
		send_link_byte(cur_marker);
		send_link_byte(len[7:0]);
		send_escaped_byte(len[15:8]);
		for (int i = 0; i < n; i++) begin
			b = ($urandom_range(0, 7) == 0) ? cur_marker : BYTE_W'($urandom);
			sum = sum + SUM_W'(b);
			send_escaped_byte(b);
		end
		if (n == int'(len)) begin
			if (bad_sum)
				sum = sum ^ SUM_W'(1 << $urandom_range(0, 15));
			send_escaped_byte(sum[7:0]);
			send_escaped_byte(sum[15:8]);
		end
	endtask

	// Rewrite the marker register only while nothing is in flight. Every
	// byte yields a result, so an empty queue means the pipeline is empty.
	task automatic write_marker(input logic [BYTE_W-1:0] value);
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cur_marker = value;
		marker_writes++;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Directed cases at the reset marker: noise outside a frame, a doubled
	// marker outside a frame, a frame carrying an escaped marker, a
	// zero-length frame, and a restart that ends in a checksum mismatch.
	task automatic test_directed();
		logic [SUM_W-1:0] s;
		send_link_byte(8'h00);
		send_link_byte(8'hFF);
		send_link_byte(cur_marker);
		send_link_byte(cur_marker);
		// three payload bytes: 0x00, the marker (escaped) and 0xFF
		s = SUM_W'(cur_marker) + 16'h00FF;
		send_link_byte(cur_marker);
		send_link_byte(8'h03);
		send_escaped_byte(8'h00);
		send_escaped_byte(8'h00);
		send_escaped_byte(cur_marker);
		send_escaped_byte(8'hFF);
		send_escaped_byte(s[7:0]);
		send_escaped_byte(s[15:8]);
		// zero-length frame: only the checksum follows, and it must be 0
		send_link_byte(cur_marker);
		send_link_byte(8'h00);
		send_link_byte(8'h00);
		send_link_byte(8'h00);
		send_link_byte(8'h00);
		// open a one-byte frame, then start again once the payload is in
		send_link_byte(cur_marker);
		send_link_byte(8'h01);
		send_link_byte(8'h00);
		send_link_byte(8'hAA);
		send_link_byte(cur_marker);
		send_link_byte(8'h01);
		send_link_byte(8'h00);
		send_link_byte(8'h55);
		send_link_byte(8'h56);
		send_link_byte(8'h00);
	endtask

	// Marker at both extremes and at a random value. Rewrite it while an
	// escape is pending; the pending escape must survive the write.
	task automatic test_marker_settings();
		write_marker(8'h00);
		repeat (3) send_frame(LEN_W'($urandom_range(1, 12)), 1'b0, -1);
		send_frame(16'd5, 1'b1, -1);
		send_link_byte(cur_marker);
		write_marker(8'hFF);
		// under the old marker 0x00 this byte would be a literal; now it
		// opens a zero-length frame
		send_link_byte(8'h00);
		send_link_byte(8'h00);
		send_link_byte(8'h00);
		send_link_byte(8'h00);
		repeat (3) send_frame(LEN_W'($urandom_range(0, 12)), 1'b0, -1);
		send_frame(16'd7, 1'b0, 3);
		send_frame(16'd2, 1'b0, -1);
		write_marker(BYTE_W'($urandom));
		repeat (3) send_frame(LEN_W'($urandom_range(0, 12)), 1'($urandom_range(0, 1)), -1);
	endtask

	// Payload limit: a frame of exactly the limit is good. A longer frame
	// is dropped on the byte that reaches the limit.
	task automatic test_length_limit();
		write_marker(MARKER_RESET);
		pacing = 1'b0;
		send_frame(LEN_W'(MAX_PAYLOAD_DEF), 1'b0, -1);
		pacing = 1'b1;
		send_frame(16'hF234, 1'b0, MAX_PAYLOAD_DEF);
		// trailing bytes after the drop are ignored until a new start
		send_link_byte(8'h12);
		send_frame(16'd4, 1'b0, -1);
	endtask

	// Random traffic: mostly well-formed frames, some with bad checksums,
	// plus link noise and frames cut short. Rewrite the marker now and then.
	task automatic test_random_traffic();
		int               first;
		int               last_cfg;
		int               kind;
		logic [LEN_W-1:0] len;
		first = bytes_sent;
		last_cfg = bytes_sent;
		while (bytes_sent - first < RANDOM_BYTES) begin
			if (bytes_sent - last_cfg >= 120) begin
				case ($urandom_range(0, 3))
					0:       write_marker(8'h00);
					1:       write_marker(8'hFF);
					default: write_marker(BYTE_W'($urandom));
				endcase
				last_cfg = bytes_sent;
			end
			pacing = ($urandom_range(0, 3) != 0);
			kind = $urandom_range(0, 9);
			len = ($urandom_range(0, 24) == 0) ? LEN_W'($urandom_range(256, 264))
				: LEN_W'($urandom_range(0, 24));
			case (kind)
				0: begin
					// line noise, markers included
					repeat ($urandom_range(1, 4))
						send_link_byte(($urandom_range(0, 3) == 0) ? cur_marker
							: BYTE_W'($urandom));
				end
				1: send_frame(LEN_W'($urandom), 1'b0, $urandom_range(0, 6));
				default: send_frame(len, ($urandom_range(0, 4) == 0), -1);
			endcase
		end
		pacing = 1'b1;
	endtask

	initial begin
		// hold reset, then release on a falling edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_marker_settings();
		test_length_limit();
		test_random_traffic();

		// drain: wait until every expected result has been seen, then a few more
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (expected_results.size() != 0) begin
			errors++;
			$display("%0t: %0d expected results never arrived", $time,
				expected_results.size());
		end

		$display("Sent %0d link bytes, checked %0d results, wrote the marker %0d times.",
			bytes_sent, results_checked, marker_writes);
		$display("Frames: %0d good, %0d bad checksum, %0d too long, %0d restarts; %0d errors.",
			n_good, n_sum_err, n_too_long, n_restart, errors);
		if (errors == 0)
			$display("PASS stuffed_frame_receiver");
		else
			$display("FAIL stuffed_frame_receiver");
		$finish;
	end

endmodule
